// ----- rtl/cfapnw_pkg.sv -----
// Shared types, widths and helpers for the color-filter nibble writer.
// No dependencies; imported by cfapnw_expand and cfa_pixel_nibble_writer.
`default_nettype none

package cfapnw_pkg;

   localparam int PIX_W   = 11;   // logical coordinate width
   localparam int POS_W   = 13;   // panel coordinate width (3*2047+2 fits)
   localparam int COLOR_W = 16;
   localparam int ADDR_W  = 20;
   localparam int NIB_W   = 4;
   localparam int CNT_W   = 2;    // subpixel count / offset, 0..3

   // Filter phase, (column + row) mod 3.
   typedef enum logic [1:0] {
      PHASE_GREEN = 2'd0,
      PHASE_BLUE  = 2'd1,
      PHASE_RED   = 2'd2
   } phase_type;

   // One pixel after bounds check: base position and how many of the
   // 3x3 (or 1x1) subpixels fall inside the panel along each axis.
   typedef struct packed {
      logic [POS_W-1:0]   col;
      logic [POS_W-1:0]   row;
      logic [COLOR_W-1:0] color;
      logic [CNT_W-1:0]   ncols;
      logic [CNT_W-1:0]   nrows;
      phase_type          phase;
   } cfapnw_item_type;

   // One subpixel write before address generation.
   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [NIB_W-1:0] nibble;
      logic             last;
   } cfapnw_sub_type;

   // Reduce 0..7 to mod 3 with two compare-subtract steps.
   function automatic phase_type mod3_small(input logic [2:0] v);
      logic [2:0] r;
      r = v;
      if (r >= 3'd3) begin
         r = r - 3'd3;
      end
      if (r >= 3'd3) begin
         r = r - 3'd3;
      end
      return phase_type'(r[1:0]);
   endfunction

   // 12-bit mod 3: base-4 digit sum (4 == 1 mod 3), fold again, then reduce.
   function automatic phase_type mod3_12(input logic [11:0] v);
      logic [4:0] s1;
      logic [2:0] s2;
      s1 = '0;
      for (int i = 0; i < 6; i++) begin
         s1 = s1 + 5'(v[2*i +: 2]);
      end
      s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
      return mod3_small(s2);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cfa_pixel_nibble_writer.sv -----
// Top level of the color-filter pixel nibble writer: input register, bounds
// stage, subpixel sequencer and address/output register. Uses cfapnw_pkg, cfapnw_expand.
`default_nettype none

// Channel   Dir  Word contents (low bit first)
// req_*     in   tdata[39:0]: pixel_x[10:0], pixel_y[10:0], color[15:0], zero pad
// rsp_*     out  tdata[31:0]: byte_addr[19:0], high_nibble, nibble_value[3:0], zero pad;
//                tlast = final write of the pixel
// csr_*     in   wr_data[0]: block_mode (1 = 3x3 block, 0 = single position)
//
// One write leaves per cycle unless rsp_tready stalls. A fine-mode pixel gives
// one write, a block-mode pixel one write per in-panel subpixel (up to nine),
// set by the sequencer. Pixels with no in-panel position are dropped and give
// no output write. A pixel passes the input, bounds, sequencer and output registers.
// Reset is synchronous; it empties every stage and sets block_mode to 1.
// Stalls on rsp_tready back up stage by stage; nothing is lost or repeated.

module cfa_pixel_nibble_writer #(
   parameter int PANEL_WIDTH  = 1448,
   parameter int PANEL_HEIGHT = 1072
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input pixels
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // pixel_x, pixel_y, color
   // nibble writes
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // byte_addr, high_nibble, nibble_value
   output      logic        rsp_tlast,
   // block_mode register
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);
   import cfapnw_pkg::*;

   localparam int HALF_W = $clog2(PANEL_WIDTH / 2 + 1);
   localparam int PROD_W = POS_W + HALF_W;
   localparam int SUM_W  = ((PROD_W > ADDR_W) ? PROD_W : ADDR_W) + 1;
   localparam logic [HALF_W-1:0] HALF = HALF_W'(PANEL_WIDTH / 2);
   localparam logic [POS_W:0]    WLIM = (POS_W + 1)'(PANEL_WIDTH);
   localparam logic [POS_W:0]    HLIM = (POS_W + 1)'(PANEL_HEIGHT);
   // an odd width puts its last column one byte past PANEL_WIDTH/2 per row
   localparam longint unsigned   FB_BYTES =
      longint'(PANEL_HEIGHT) * longint'((PANEL_WIDTH + 1) / 2);

   // mode register
   logic block_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         block_mode_ff <= csr_wr_data;
      end
   end

   // ---- stage A: input register ----
   logic               a_valid_ff, a_valid_in, a_free;
   logic [PIX_W-1:0]   a_px_ff, a_py_ff;
   logic [COLOR_W-1:0] a_color_ff;
   logic               a_mode_ff;

   // ---- stage B: bounds-checked pixel ----
   logic               b_valid_ff, b_valid_in, b_free;
   cfapnw_item_type    b_item_ff, b_item_in;
   logic               exp_in_ready;

   // ---- sequencer out / stage E ----
   logic               exp_out_valid, e_free;
   cfapnw_sub_type     exp_sub;
   logic               e_valid_ff, e_valid_in;
   logic [ADDR_W-1:0]  e_addr_ff;
   logic               e_high_ff;
   logic [NIB_W-1:0]   e_nib_ff;
   logic               e_last_ff;

   assign b_free     = !b_valid_ff || exp_in_ready;
   assign a_free     = !a_valid_ff || b_free;
   assign req_tready = a_free;
   assign a_valid_in = a_free ? req_tvalid : a_valid_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && a_free) begin
         a_px_ff    <= req_tdata[10:0];
         a_py_ff    <= req_tdata[21:11];
         a_color_ff <= req_tdata[37:22];
         a_mode_ff  <= block_mode_ff;
      end
   end

   // Base position (x3 in block mode) and count of in-panel columns/rows.
   logic [POS_W-1:0] base_col, base_row;
   logic             c0, c1, c2, r0, r1, r2;
   logic [CNT_W-1:0] ncols, nrows;

   always_comb begin
      base_col = a_mode_ff ? (POS_W'({a_px_ff, 1'b0}) + POS_W'(a_px_ff)) : POS_W'(a_px_ff);
      base_row = a_mode_ff ? (POS_W'({a_py_ff, 1'b0}) + POS_W'(a_py_ff)) : POS_W'(a_py_ff);
      c0 = ((POS_W + 1)'(base_col))         < WLIM;
      c1 = ((POS_W + 1)'(base_col) + 14'd1) < WLIM;
      c2 = ((POS_W + 1)'(base_col) + 14'd2) < WLIM;
      r0 = ((POS_W + 1)'(base_row))         < HLIM;
      r1 = ((POS_W + 1)'(base_row) + 14'd1) < HLIM;
      r2 = ((POS_W + 1)'(base_row) + 14'd2) < HLIM;
      if (!a_mode_ff) begin
         ncols = {1'b0, c0};
         nrows = {1'b0, r0};
      end else begin
         ncols = c2 ? 2'd3 : c1 ? 2'd2 : {1'b0, c0};
         nrows = r2 ? 2'd3 : r1 ? 2'd2 : {1'b0, r0};
      end
      b_item_in.col   = base_col;
      b_item_in.row   = base_row;
      b_item_in.color = a_color_ff;
      b_item_in.ncols = ncols;
      b_item_in.nrows = nrows;
      // block origin sits at a multiple of 3 on both axes: phase starts at green
      b_item_in.phase = a_mode_ff ? PHASE_GREEN
                                  : mod3_12(12'(a_px_ff) + 12'(a_py_ff));
   end

   // pixels entirely off panel are dropped here
   assign b_valid_in = b_free ? (a_valid_ff && (ncols != '0) && (nrows != '0)) : b_valid_ff;

   always_ff @(posedge clock) begin
      if (b_free) begin
         b_item_ff <= b_item_in;
      end
   end

   cfapnw_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_ready  (exp_in_ready),
      .in_item   (b_item_ff),
      .out_valid (exp_out_valid),
      .out_ready (e_free),
      .out_sub   (exp_sub)
   );

   // ---- stage E: address multiply and output register ----
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  addr_sum;

   assign e_free     = !e_valid_ff || rsp_tready;
   assign e_valid_in = e_free ? exp_out_valid : e_valid_ff;
   assign prod       = PROD_W'(exp_sub.row) * PROD_W'(HALF);
   assign addr_sum   = SUM_W'(prod) + SUM_W'(exp_sub.col[POS_W-1:1]);

   always_ff @(posedge clock) begin
      if (e_free) begin
         e_addr_ff <= addr_sum[ADDR_W-1:0];
         e_high_ff <= exp_sub.col[0];
         e_nib_ff  <= exp_sub.nibble;
         e_last_ff <= exp_sub.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   assign rsp_tvalid = e_valid_ff;
   assign rsp_tdata  = {7'd0, e_nib_ff, e_high_ff, e_addr_ff};
   assign rsp_tlast  = e_last_ff;

   // ---- checks ----
   // only pixels with at least one in-panel position reach the sequencer
   a_b_nonempty: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_item_ff.ncols != '0) && (b_item_ff.nrows != '0))
      else $error("empty pixel entered sequencer");

   // bounds stage holds its pixel while the sequencer is busy
   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !exp_in_ready |=> b_valid_ff && $stable(b_item_ff))
      else $error("bounds stage lost a pixel under stall");

   // every address lands inside the framebuffer, when the framebuffer fits 20 address bits
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> (64'(e_addr_ff) < 64'(FB_BYTES)) || (FB_BYTES > 64'hFFFFF))
      else $error("write address beyond framebuffer");

   // nothing can reach the output register without passing the earlier stages
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(e_valid_ff) |-> $past(exp_out_valid))
      else $error("output word without sequencer word");

endmodule

`default_nettype wire

// ----- rtl/cfapnw_expand.sv -----
// Subpixel sequencer: walks the in-panel part of each pixel block, one
// write per cycle while the output is not stalled, registered output. Depends on cfapnw_pkg.
`default_nettype none

module cfapnw_expand (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output      logic                        in_ready,
   input  wire cfapnw_pkg::cfapnw_item_type in_item,
   output      logic                        out_valid,
   input  wire logic                        out_ready,
   output      cfapnw_pkg::cfapnw_sub_type  out_sub
);
   import cfapnw_pkg::*;

   cfapnw_item_type  item_ff;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   cfapnw_sub_type   sub_ff, sub_in;
   logic             sub_valid_ff, sub_valid_in;

   logic             sub_free, emit, at_end, take;
   phase_type        ph;
   logic [NIB_W-1:0] nib;

   assign sub_free = !sub_valid_ff || out_ready;
   assign emit     = busy_ff && sub_free;
   assign at_end   = (dx_ff == item_ff.ncols - 2'd1) && (dy_ff == item_ff.nrows - 2'd1);
   assign in_ready = !busy_ff || (emit && at_end);
   assign take     = in_valid && in_ready;

   assign ph = mod3_small(3'(item_ff.phase) + 3'(dx_ff) + 3'(dy_ff));

   always_comb begin
      case (ph)
         PHASE_GREEN: nib = item_ff.color[10:7];
         PHASE_BLUE:  nib = item_ff.color[4:1];
         PHASE_RED:   nib = item_ff.color[15:12];
         default:     nib = item_ff.color[15:12];
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      if (take) begin
         busy_in = 1'b1;
         dx_in   = '0;
         dy_in   = '0;
      end else if (emit) begin
         if (at_end) begin
            busy_in = 1'b0;
         end
         if (dx_ff == item_ff.ncols - 2'd1) begin
            dx_in = '0;
            dy_in = dy_ff + 2'd1;
         end else begin
            dx_in = dx_ff + 2'd1;
         end
      end
   end

   always_comb begin
      sub_valid_in = sub_free ? emit : sub_valid_ff;
      sub_in       = sub_ff;
      if (emit) begin
         sub_in.col    = item_ff.col + POS_W'(dx_ff);
         sub_in.row    = item_ff.row + POS_W'(dy_ff);
         sub_in.nibble = nib;
         sub_in.last   = at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sub_valid_ff <= 1'b0;
         dx_ff        <= '0;
         dy_ff        <= '0;
      end else begin
         busy_ff      <= busy_in;
         sub_valid_ff <= sub_valid_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= in_item;
      end
      sub_ff <= sub_in;
   end

   assign out_valid = sub_valid_ff;
   assign out_sub   = sub_ff;

endmodule

`default_nettype wire
